// ----- hdl/dnpg_pkg.sv -----
// Shared types, constants and state codes of the digital net point generator.
`timescale 1ns / 1ps

package dnpg_pkg;

    // Default sizing handed to the top level parameters
    localparam int DEF_MAX_DIMS   = 8;
    localparam int DEF_MAX_DIGITS = 16;
    localparam int DEF_DIGIT_BITS = 4;

    // Fixed field widths
    localparam int BASE_W      = 5;
    localparam int COUNT_W     = 5;
    localparam int DIM_W       = 3;
    localparam int RC_W        = 4;
    localparam int ENTRY_W     = 4;
    localparam int INDEX_W     = 64;
    localparam int COORD_W     = 64;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int BIT_CNT_W   = 7;   // holds INDEX_W

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASE        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(1);

    // Reset values of the registers
    localparam logic [BASE_W-1:0]  RST_BASE        = BASE_W'(2);
    localparam logic [COUNT_W-1:0] RST_DIGIT_COUNT = COUNT_W'(16);

    // Command kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Command beat
    typedef struct packed {
        logic               kind;
        logic [DIM_W-1:0]   dimension;
        logic [RC_W-1:0]    row;
        logic [RC_W-1:0]    column;
        logic [ENTRY_W-1:0] entry;
        logic [INDEX_W-1:0] point_index;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [COORD_W-1:0] coordinate;
        logic [DIM_W-1:0]   out_dimension;
    } t_result;

    // Query sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAT,
        ST_DRAIN,
        ST_RED,
        ST_ACC
    } t_state;

endpackage

// ----- hdl/dnpg_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module dnpg_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/digital_net_point_generator.sv -----
// Top level of the base-p digital net point generator.
`timescale 1ns / 1ps

// A load beat (kind 0) writes one generator matrix digit in its accept cycle
// and leaves busy low, so loads go one per cycle. A query beat (kind 1) raises
// busy until its result strobe. The index is split into m base-p digits by a
// bit-serial restoring divider; then each of the m rows is summed over m
// columns at one matrix entry per cycle from the coefficient RAM, reduced mod
// p by the same divider over the SUM_W-bit row sum and folded into the
// numerator. A query for a dimension beyond the store or with m = 0 answers in
// the next cycle. The result is shown for one cycle on o_valid and cannot be
// held off. No clearing pass runs after reset; the matrices must be loaded
// before they are queried. The configuration port is always ready and is to be
// written only while idle; the block itself does not enforce this.
module digital_net_point_generator #(
    parameter int MAX_DIMS   = dnpg_pkg::DEF_MAX_DIMS,
    parameter int MAX_DIGITS = dnpg_pkg::DEF_MAX_DIGITS,
    parameter int DIGIT_BITS = dnpg_pkg::DEF_DIGIT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  dnpg_pkg::t_cmd                      i_cmd,
    // result channel
    output logic                                o_valid,
    output dnpg_pkg::t_result                   o_result,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dnpg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dnpg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = MAX_DIMS * MAX_DIGITS * MAX_DIGITS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW     = $clog2(MAX_DIGITS + 1);
    localparam int IW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int SUM_W  = DIGIT_BITS + dnpg_pkg::BASE_W + $clog2(MAX_DIGITS + 1);
    localparam int BW     = dnpg_pkg::BASE_W;

    // Registers
    dnpg_pkg::t_state                  r_state, n_state;
    logic [BW-1:0]                     r_base;
    logic [dnpg_pkg::COUNT_W-1:0]      r_digit_count;
    logic [dnpg_pkg::DIM_W-1:0]        r_dim;
    logic [MW-1:0]                     r_m;
    logic [MW-1:0]                     r_k;
    logic [MW-1:0]                     r_i;
    logic [dnpg_pkg::INDEX_W-1:0]      r_n;
    logic [BW-1:0]                     r_rem;
    logic [dnpg_pkg::BIT_CNT_W-1:0]    r_bits;
    logic [SUM_W-1:0]                  r_sum;
    logic                              r_rd_vld;
    logic [dnpg_pkg::COORD_W-1:0]      r_acc;
    logic                              r_out_vld;
    dnpg_pkg::t_result                 r_result;

    // Combinational
    logic                              cmd_acc;
    logic                              query_ok;
    logic                              load_ok;
    logic [BW-1:0]                     p_eff;
    logic [MW-1:0]                     m_eff;
    logic                              k_last;
    logic                              i_last;
    logic [BW:0]                       div_t;
    logic                              div_ge;
    logic [BW-1:0]                     div_rem;
    logic [SUM_W-1:0]                  prod;
    logic [SUM_W-1:0]                  sum_nxt;
    logic [dnpg_pkg::COORD_W-1:0]      acc_nxt;
    logic                              coef_we;
    logic [ADDR_W-1:0]                 coef_waddr;
    logic [DIGIT_BITS-1:0]             coef_wdata;
    logic                              coef_re;
    logic [ADDR_W-1:0]                 coef_raddr;
    logic [DIGIT_BITS-1:0]             coef_q;
    logic                              dig_we;
    logic [BW-1:0]                     dig_q;

    // Effective base and digit count
    assign p_eff = (r_base < BW'(2)) ? BW'(2) : r_base;
    assign m_eff = (int'(r_digit_count) > MAX_DIGITS) ? MW'(MAX_DIGITS)
                                                      : MW'(r_digit_count);

    assign cmd_acc  = start && (r_state == dnpg_pkg::ST_IDLE);
    assign query_ok = (int'(i_cmd.dimension) < MAX_DIMS) && (m_eff != '0);
    assign load_ok  = (int'(i_cmd.dimension) < MAX_DIMS) &&
                      (int'(i_cmd.row) < MAX_DIGITS) &&
                      (int'(i_cmd.column) < MAX_DIGITS);

    assign k_last = (MW'(r_k + MW'(1)) == r_m);
    assign i_last = (MW'(r_i + MW'(1)) == r_m);

    // One restoring division step: shift in the next dividend bit
    assign div_t   = {r_rem, r_n[dnpg_pkg::INDEX_W-1]};
    assign div_ge  = (div_t >= {1'b0, p_eff});
    assign div_rem = div_ge ? BW'(div_t - {1'b0, p_eff}) : BW'(div_t);

    // Row sum and numerator update
    assign prod    = SUM_W'(coef_q) * SUM_W'(dig_q);
    assign sum_nxt = r_sum + (r_rd_vld ? prod : '0);
    assign acc_nxt = r_acc * dnpg_pkg::COORD_W'(p_eff) + dnpg_pkg::COORD_W'(r_rem);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dnpg_pkg::ST_IDLE: begin
                if (cmd_acc && (i_cmd.kind == dnpg_pkg::KIND_QUERY) && query_ok) begin
                    n_state = dnpg_pkg::ST_DIV;
                end
            end
            dnpg_pkg::ST_DIV: begin
                if ((r_bits == dnpg_pkg::BIT_CNT_W'(1)) && k_last) begin
                    n_state = dnpg_pkg::ST_MAT;
                end
            end
            dnpg_pkg::ST_MAT: begin
                if (k_last) begin
                    n_state = dnpg_pkg::ST_DRAIN;
                end
            end
            dnpg_pkg::ST_DRAIN: begin
                n_state = dnpg_pkg::ST_RED;
            end
            dnpg_pkg::ST_RED: begin
                if (r_bits == dnpg_pkg::BIT_CNT_W'(1)) begin
                    n_state = dnpg_pkg::ST_ACC;
                end
            end
            dnpg_pkg::ST_ACC: begin
                n_state = i_last ? dnpg_pkg::ST_IDLE : dnpg_pkg::ST_MAT;
            end
            default: begin
                n_state = dnpg_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        busy        = (r_state != dnpg_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
        coef_we     = cmd_acc && (i_cmd.kind == dnpg_pkg::KIND_LOAD) && load_ok;
        coef_waddr  = ADDR_W'((int'(i_cmd.dimension) * MAX_DIGITS + int'(i_cmd.row))
                              * MAX_DIGITS + int'(i_cmd.column));
        coef_wdata  = DIGIT_BITS'(i_cmd.entry);
        coef_re     = (r_state == dnpg_pkg::ST_MAT);
        coef_raddr  = ADDR_W'((int'(r_dim) * MAX_DIGITS + int'(r_i))
                              * MAX_DIGITS + int'(r_k));
        dig_we      = (r_state == dnpg_pkg::ST_DIV) && (r_bits == dnpg_pkg::BIT_CNT_W'(1));
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dnpg_pkg::ST_IDLE;
            r_base        <= dnpg_pkg::RST_BASE;
            r_digit_count <= dnpg_pkg::RST_DIGIT_COUNT;
            r_rd_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= 1'b0;
            r_rd_vld  <= (r_state == dnpg_pkg::ST_MAT);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dnpg_pkg::REG_BASE:        r_base        <= BW'(i_cfg_data);
                    dnpg_pkg::REG_DIGIT_COUNT: r_digit_count <= dnpg_pkg::COUNT_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (cmd_acc && (i_cmd.kind == dnpg_pkg::KIND_QUERY) && !query_ok) begin
                r_out_vld <= 1'b1;
            end
            if ((r_state == dnpg_pkg::ST_ACC) && i_last) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            dnpg_pkg::ST_IDLE: begin
                if (cmd_acc && (i_cmd.kind == dnpg_pkg::KIND_QUERY)) begin
                    r_dim  <= i_cmd.dimension;
                    r_m    <= m_eff;
                    r_n    <= i_cmd.point_index;
                    r_rem  <= '0;
                    r_bits <= dnpg_pkg::BIT_CNT_W'(dnpg_pkg::INDEX_W);
                    r_k    <= '0;
                    r_i    <= '0;
                    r_acc  <= '0;
                    r_sum  <= '0;
                    r_result.coordinate    <= '0;
                    r_result.out_dimension <= i_cmd.dimension;
                end
            end
            // split the index: quotient bits shift into r_n
            dnpg_pkg::ST_DIV: begin
                r_n <= {r_n[dnpg_pkg::INDEX_W-2:0], div_ge};
                if (r_bits == dnpg_pkg::BIT_CNT_W'(1)) begin
                    r_rem  <= '0;
                    r_bits <= dnpg_pkg::BIT_CNT_W'(dnpg_pkg::INDEX_W);
                    r_k    <= k_last ? '0 : MW'(r_k + MW'(1));
                end else begin
                    r_rem  <= div_rem;
                    r_bits <= r_bits - dnpg_pkg::BIT_CNT_W'(1);
                end
            end
            // one entry read per cycle, product added in the next cycle
            dnpg_pkg::ST_MAT: begin
                r_sum <= sum_nxt;
                r_k   <= k_last ? '0 : MW'(r_k + MW'(1));
            end
            // last product in; row sum goes to the divider, left aligned
            dnpg_pkg::ST_DRAIN: begin
                r_n    <= dnpg_pkg::INDEX_W'(sum_nxt) << (dnpg_pkg::INDEX_W - SUM_W);
                r_rem  <= '0;
                r_bits <= dnpg_pkg::BIT_CNT_W'(SUM_W);
            end
            dnpg_pkg::ST_RED: begin
                r_n    <= {r_n[dnpg_pkg::INDEX_W-2:0], div_ge};
                r_rem  <= div_rem;
                r_bits <= r_bits - dnpg_pkg::BIT_CNT_W'(1);
            end
            // fold the row digit into the numerator, row 0 most significant
            dnpg_pkg::ST_ACC: begin
                r_acc <= acc_nxt;
                r_sum <= '0;
                r_i   <= MW'(r_i + MW'(1));
                if (i_last) begin
                    r_result.coordinate <= acc_nxt;
                end
            end
            default: ;
        endcase
    end

    // Generator matrices
    dnpg_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_re    (coef_re),
        .i_raddr (coef_raddr),
        .o_rdata (coef_q)
    );

    // Digit vector of the current index
    dnpg_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (dig_we),
        .i_waddr (r_k[IW-1:0]),
        .i_wdata (div_rem),
        .i_re    (coef_re),
        .i_raddr (r_k[IW-1:0]),
        .o_rdata (dig_q)
    );

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

endmodule
